// ===== src/skf_pkg.sv =====
// Package for the scalar Kalman filter: fixed-point widths, register indexes,
// datapath command and status types shared by the controller and the datapath.
// No dependencies.
`default_nettype none

package skf_pkg;

  // Number format: signed Q16.16 in a 32-bit word
  localparam int DATA_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int NUM_W      = DATA_W + FRAC_W;
  localparam int NOISE_W    = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef logic signed [DATA_W-1:0] fx_t;

  localparam fx_t FX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam fx_t FX_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam fx_t FX_ONE = fx_t'(64'd1 << FRAC_W);

  // Register reset values
  localparam logic [NOISE_W-1:0] Q_NOISE_RST = '0;
  localparam logic [NOISE_W-1:0] R_NOISE_RST = NOISE_W'(64'd1 << FRAC_W);
  localparam fx_t                H_GAIN_RST  = FX_ONE;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_Q_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_R_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_H_GAIN  = 2'd2;

  // Item kinds
  localparam logic KIND_MEASURE = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_LOAD,
    ALU_RESTART,
    ALU_MUL,
    ALU_RND,
    ALU_ADD,
    ALU_SUB,
    ALU_DIV_INIT,
    ALU_DIV_FIN,
    ALU_KZERO
  } alu_op_t;

  typedef enum logic [3:0] {
    OPD_ZERO,
    OPD_P,
    OPD_H,
    OPD_EST,
    OPD_HP,
    OPD_T,
    OPD_K,
    OPD_Z,
    OPD_R,
    OPD_Q,
    OPD_ONE
  } opd_t;

  typedef enum logic [2:0] {
    DST_NONE,
    DST_HP,
    DST_T,
    DST_DEN,
    DST_K,
    DST_EST,
    DST_P
  } dst_t;

  typedef struct packed {
    alu_op_t op;
    opd_t    sel_a;
    opd_t    sel_b;
    dst_t    dst;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic div_busy;
    logic div_done;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/skf_if.sv =====
// Valid/ready channel interfaces of the scalar Kalman filter: input items
// and result items. Depends on skf_pkg.
`default_nettype none

interface skf_in_if;
  import skf_pkg::*;

  logic valid;
  logic ready;
  logic kind;
  fx_t  measurement;

  modport source (output valid, output kind, output measurement, input ready);
  modport sink   (input valid, input kind, input measurement, output ready);
endinterface

interface skf_out_if;
  import skf_pkg::*;

  logic valid;
  logic ready;
  fx_t  estimate;
  fx_t  gain;
  logic div_zero;
  logic saturated;

  modport source (output valid, output estimate, output gain, output div_zero,
                  output saturated, input ready);
  modport sink   (input valid, input estimate, input gain, input div_zero,
                  input saturated, output ready);
endinterface

`default_nettype wire

// ===== src/skf_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle, for the gain.
// Depends on skf_pkg.
`default_nettype none

module skf_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [skf_pkg::NUM_W-1:0]  num,
  input  logic [skf_pkg::DATA_W-1:0] den,
  output logic                       busy,
  output logic                       done,
  output logic [skf_pkg::NUM_W-1:0]  quo
);
  import skf_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

  logic [NUM_W-1:0]  quo_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] den_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DATA_W:0]   rem_sh;
  logic              fits;
  logic [DATA_W-1:0] rem_nxt;

  // Trial subtract of the shifted remainder
  assign rem_sh  = {rem_r, quo_r[NUM_W-1]};
  assign fits    = rem_sh >= {1'b0, den_r};
  assign rem_nxt = fits ? DATA_W'(rem_sh - {1'b0, den_r}) : rem_sh[DATA_W-1:0];

  // Step counter and handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Numerator shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

// ===== src/skf_datapath.sv =====
// Datapath of the scalar Kalman filter: filter state, configuration
// registers, shared multiplier, rounding, add/sub with clamping, divider.
// Depends on skf_pkg and skf_divider.
`default_nettype none

module skf_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  skf_pkg::dp_cmd_t              cmd,
  output skf_pkg::dp_stat_t             stat,
  input  skf_pkg::fx_t                  in_meas,
  input  logic                          cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [skf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output skf_pkg::fx_t                  out_est,
  output skf_pkg::fx_t                  out_gain,
  output logic                          out_dz,
  output logic                          out_sat
);
  import skf_pkg::*;

  localparam logic [PROD_W-1:0] HALF = PROD_W'(64'd1) << (FRAC_W - 1);

  // Filter state and configuration
  fx_t                est_r;
  fx_t                cov_r;
  logic [NOISE_W-1:0] q_r;
  logic [NOISE_W-1:0] r_r;
  fx_t                h_r;
  logic               sat_r;
  logic               dz_r;

  // Working registers
  fx_t                      hp_r;
  fx_t                      t_r;
  fx_t                      den_r;
  fx_t                      k_r;
  fx_t                      z_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     neg_r;
  fx_t                      out_est_r;
  fx_t                      out_gain_r;
  logic                     out_dz_r;
  logic                     out_sat_r;

  fx_t opd_a;
  fx_t opd_b;

  logic signed [PROD_W-1:0] mul_full;
  logic signed [PROD_W-1:0] rnd_sum;
  logic signed [PROD_W-1:0] rnd_shift;
  logic [PROD_W-DATA_W:0]   rnd_top;
  logic signed [DATA_W:0]   sum_ext;
  logic [DATA_W-1:0]        hp_u;
  logic [DATA_W-1:0]        den_u;
  logic [DATA_W-1:0]        hp_mag;
  logic [DATA_W-1:0]        den_mag;
  logic [NUM_W-1:0]         div_num;
  logic [NUM_W-1:0]         quo;
  logic                     quo_big;
  logic                     div_busy;
  logic                     div_done;
  logic                     div_start;

  fx_t  alu_res;
  logic alu_sat;
  logic alu_wr;

  // Operand selection
  function automatic fx_t pick(opd_t sel, fx_t p, fx_t h, fx_t e, fx_t hp, fx_t t,
                               fx_t k, fx_t z, logic [NOISE_W-1:0] r,
                               logic [NOISE_W-1:0] q);
    fx_t v;
    case (sel)
      OPD_P:   v = p;
      OPD_H:   v = h;
      OPD_EST: v = e;
      OPD_HP:  v = hp;
      OPD_T:   v = t;
      OPD_K:   v = k;
      OPD_Z:   v = z;
      OPD_R:   v = fx_t'({1'b0, r});
      OPD_Q:   v = fx_t'({1'b0, q});
      OPD_ONE: v = FX_ONE;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign opd_a = pick(cmd.sel_a, cov_r, h_r, est_r, hp_r, t_r, k_r, z_r, r_r, q_r);
  assign opd_b = pick(cmd.sel_b, cov_r, h_r, est_r, hp_r, t_r, k_r, z_r, r_r, q_r);

  assign mul_full = opd_a * opd_b;

  // Product rounding: ties away from zero, then arithmetic shift
  assign rnd_sum   = prod_r + $signed(prod_r[PROD_W-1] ? HALF - PROD_W'(1) : HALF);
  assign rnd_shift = rnd_sum >>> FRAC_W;
  assign rnd_top   = rnd_shift[PROD_W-1:DATA_W-1];

  // Add or subtract at one extra bit
  assign sum_ext = (cmd.op == ALU_SUB) ?
                   ({opd_a[DATA_W-1], opd_a} - {opd_b[DATA_W-1], opd_b}) :
                   ({opd_a[DATA_W-1], opd_a} + {opd_b[DATA_W-1], opd_b});

  // Divider operands: (|hp| << FRAC_W) + |den| / 2
  assign hp_u    = hp_r;
  assign den_u   = den_r;
  assign hp_mag  = hp_r[DATA_W-1] ? (~hp_u + DATA_W'(1)) : hp_u;
  assign den_mag = den_r[DATA_W-1] ? (~den_u + DATA_W'(1)) : den_u;
  assign div_num = {hp_mag, {FRAC_W{1'b0}}} + NUM_W'(den_mag >> 1);
  assign div_start = (cmd.op == ALU_DIV_INIT);

  skf_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (den_mag),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (quo)
  );

  // Quotient too large for the signed range
  assign quo_big = neg_r ?
                   ((|quo[NUM_W-1:DATA_W]) || (quo[DATA_W-1] && (|quo[DATA_W-2:0]))) :
                   (|quo[NUM_W-1:DATA_W-1]);

  // Result of the write-back operations
  always_comb begin
    alu_res = '0;
    alu_sat = 1'b0;
    alu_wr  = 1'b0;
    case (cmd.op)
      ALU_RND: begin
        alu_wr = 1'b1;
        if ((&rnd_top) || !(|rnd_top)) begin
          alu_res = rnd_shift[DATA_W-1:0];
        end else begin
          alu_sat = 1'b1;
          alu_res = rnd_shift[PROD_W-1] ? FX_MIN : FX_MAX;
        end
      end
      ALU_ADD, ALU_SUB: begin
        alu_wr = 1'b1;
        if (sum_ext[DATA_W] == sum_ext[DATA_W-1]) begin
          alu_res = sum_ext[DATA_W-1:0];
        end else begin
          alu_sat = 1'b1;
          alu_res = sum_ext[DATA_W] ? FX_MIN : FX_MAX;
        end
      end
      ALU_DIV_FIN: begin
        alu_wr = 1'b1;
        if (quo_big) begin
          alu_sat = 1'b1;
          alu_res = neg_r ? FX_MIN : FX_MAX;
        end else if (neg_r) begin
          alu_res = fx_t'(~quo[DATA_W-1:0] + DATA_W'(1));
        end else begin
          alu_res = fx_t'(quo[DATA_W-1:0]);
        end
      end
      default: begin
        alu_wr = 1'b0;
      end
    endcase
  end

  // Filter state, flags and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_r <= '0;
      cov_r <= '0;
      q_r   <= Q_NOISE_RST;
      r_r   <= R_NOISE_RST;
      h_r   <= H_GAIN_RST;
      sat_r <= 1'b0;
      dz_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_Q_NOISE: q_r <= cfg_wdata[NOISE_W-1:0];
          CFG_R_NOISE: r_r <= cfg_wdata[NOISE_W-1:0];
          CFG_H_GAIN:  h_r <= fx_t'(cfg_wdata[DATA_W-1:0]);
          default:     ;
        endcase
      end
      case (cmd.op)
        ALU_LOAD: begin
          sat_r <= 1'b0;
          dz_r  <= 1'b0;
        end
        ALU_RESTART: begin
          est_r <= '0;
          cov_r <= '0;
          sat_r <= 1'b0;
          dz_r  <= 1'b0;
        end
        ALU_KZERO: begin
          dz_r <= 1'b1;
        end
        default: begin
          if (alu_wr) begin
            sat_r <= sat_r | alu_sat;
            if (cmd.dst == DST_EST) est_r <= alu_res;
            if (cmd.dst == DST_P)   cov_r <= alu_res;
          end
        end
      endcase
    end
  end

  // Working registers and result holding register
  always_ff @(posedge clk) begin
    case (cmd.op)
      ALU_LOAD:     z_r    <= in_meas;
      ALU_RESTART:  k_r    <= '0;
      ALU_KZERO:    k_r    <= '0;
      ALU_MUL:      prod_r <= mul_full;
      ALU_DIV_INIT: neg_r  <= hp_r[DATA_W-1] ^ den_r[DATA_W-1];
      default: begin
        if (alu_wr) begin
          case (cmd.dst)
            DST_HP:  hp_r  <= alu_res;
            DST_T:   t_r   <= alu_res;
            DST_DEN: den_r <= alu_res;
            DST_K:   k_r   <= alu_res;
            default: ;
          endcase
        end
      end
    endcase
    if (cmd.load_out) begin
      out_est_r  <= est_r;
      out_gain_r <= k_r;
      out_dz_r   <= dz_r;
      out_sat_r  <= sat_r;
    end
  end

  assign stat.den_zero = (den_r == '0);
  assign stat.div_busy = div_busy;
  assign stat.div_done = div_done;

  assign out_est  = out_est_r;
  assign out_gain = out_gain_r;
  assign out_dz   = out_dz_r;
  assign out_sat  = out_sat_r;

endmodule

`default_nettype wire

// ===== src/skf_ctrl.sv =====
// Controller of the scalar Kalman filter: sequences the datapath through one
// filter step and owns the item handshakes. Depends on skf_pkg.
`default_nettype none

module skf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output skf_pkg::dp_cmd_t  cmd,
  input  skf_pkg::dp_stat_t stat
);
  import skf_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_PH,
    ST_RND_HP,
    ST_MUL_HH,
    ST_RND_HH,
    ST_ADD_DEN,
    ST_CHK_DEN,
    ST_DIV_WAIT,
    ST_DIV_FIN,
    ST_MUL_HX,
    ST_RND_HX,
    ST_SUB_INNOV,
    ST_MUL_KI,
    ST_RND_KI,
    ST_ADD_EST,
    ST_MUL_KH,
    ST_RND_KH,
    ST_SUB_ONE,
    ST_MUL_CP,
    ST_RND_CP,
    ST_ADD_COV,
    ST_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  // Command decode and next state
  always_comb begin
    cmd          = '{op: ALU_NOP, sel_a: OPD_ZERO, sel_b: OPD_ZERO,
                     dst: DST_NONE, load_out: 1'b0};
    state_nxt    = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_RESTART) begin
            cmd.op    = ALU_RESTART;
            state_nxt = ST_DONE;
          end else begin
            cmd.op    = ALU_LOAD;
            state_nxt = ST_MUL_PH;
          end
        end
      end
      // hp = P * H
      ST_MUL_PH: begin
        cmd.op = ALU_MUL; cmd.sel_a = OPD_P; cmd.sel_b = OPD_H;
        state_nxt = ST_RND_HP;
      end
      ST_RND_HP: begin
        cmd.op = ALU_RND; cmd.dst = DST_HP;
        state_nxt = ST_MUL_HH;
      end
      // den = hp * H + R
      ST_MUL_HH: begin
        cmd.op = ALU_MUL; cmd.sel_a = OPD_HP; cmd.sel_b = OPD_H;
        state_nxt = ST_RND_HH;
      end
      ST_RND_HH: begin
        cmd.op = ALU_RND; cmd.dst = DST_T;
        state_nxt = ST_ADD_DEN;
      end
      ST_ADD_DEN: begin
        cmd.op = ALU_ADD; cmd.sel_a = OPD_T; cmd.sel_b = OPD_R; cmd.dst = DST_DEN;
        state_nxt = ST_CHK_DEN;
      end
      // k = hp / den, or zero with the flag
      ST_CHK_DEN: begin
        if (stat.den_zero) begin
          cmd.op    = ALU_KZERO;
          state_nxt = ST_MUL_HX;
        end else begin
          cmd.op    = ALU_DIV_INIT;
          state_nxt = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (stat.div_done) state_nxt = ST_DIV_FIN;
      end
      ST_DIV_FIN: begin
        cmd.op = ALU_DIV_FIN; cmd.dst = DST_K;
        state_nxt = ST_MUL_HX;
      end
      // innovation = z - H * est
      ST_MUL_HX: begin
        cmd.op = ALU_MUL; cmd.sel_a = OPD_H; cmd.sel_b = OPD_EST;
        state_nxt = ST_RND_HX;
      end
      ST_RND_HX: begin
        cmd.op = ALU_RND; cmd.dst = DST_T;
        state_nxt = ST_SUB_INNOV;
      end
      ST_SUB_INNOV: begin
        cmd.op = ALU_SUB; cmd.sel_a = OPD_Z; cmd.sel_b = OPD_T; cmd.dst = DST_T;
        state_nxt = ST_MUL_KI;
      end
      // est = est + k * innovation
      ST_MUL_KI: begin
        cmd.op = ALU_MUL; cmd.sel_a = OPD_K; cmd.sel_b = OPD_T;
        state_nxt = ST_RND_KI;
      end
      ST_RND_KI: begin
        cmd.op = ALU_RND; cmd.dst = DST_T;
        state_nxt = ST_ADD_EST;
      end
      ST_ADD_EST: begin
        cmd.op = ALU_ADD; cmd.sel_a = OPD_EST; cmd.sel_b = OPD_T; cmd.dst = DST_EST;
        state_nxt = ST_MUL_KH;
      end
      // P = (1 - k * H) * P + Q
      ST_MUL_KH: begin
        cmd.op = ALU_MUL; cmd.sel_a = OPD_K; cmd.sel_b = OPD_H;
        state_nxt = ST_RND_KH;
      end
      ST_RND_KH: begin
        cmd.op = ALU_RND; cmd.dst = DST_T;
        state_nxt = ST_SUB_ONE;
      end
      ST_SUB_ONE: begin
        cmd.op = ALU_SUB; cmd.sel_a = OPD_ONE; cmd.sel_b = OPD_T; cmd.dst = DST_T;
        state_nxt = ST_MUL_CP;
      end
      ST_MUL_CP: begin
        cmd.op = ALU_MUL; cmd.sel_a = OPD_T; cmd.sel_b = OPD_P;
        state_nxt = ST_RND_CP;
      end
      ST_RND_CP: begin
        cmd.op = ALU_RND; cmd.dst = DST_T;
        state_nxt = ST_ADD_COV;
      end
      ST_ADD_COV: begin
        cmd.op = ALU_ADD; cmd.sel_a = OPD_T; cmd.sel_b = OPD_Q; cmd.dst = DST_P;
        state_nxt = ST_DONE;
      end
      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // State and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== src/scalar_kalman_filter.sv =====
// Top level of the scalar Kalman filter: controller, datapath and ports.
// Depends on skf_pkg, skf_if, skf_ctrl and skf_datapath.
//
//   channel   direction  handshake     payload
//   in_item   in         valid/ready   kind, measurement
//   out_item  out        valid/ready   estimate, gain, div_zero, saturated
//   cfg_*     in         cfg_we        cfg_index, cfg_wdata
//
// A measurement item works through the 48-step gain divider and six passes
// through the shared multiplier; the divider is skipped when the divisor is
// zero. One item is in work at a time; the output register holds a result
// while the next item is accepted and worked on, and a finished item waits
// only if that register is still full. Reset is synchronous, active low, and
// clears estimate and covariance and loads register defaults.
`default_nettype none

module scalar_kalman_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  skf_in_if.sink                         in_item,
  skf_out_if.source                      out_item,
  input  logic                           cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [skf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import skf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  skf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_kind   (in_item.kind),
    .in_ready  (in_item.ready),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  skf_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_meas   (in_item.measurement),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_est   (out_item.estimate),
    .out_gain  (out_item.gain),
    .out_dz    (out_item.div_zero),
    .out_sat   (out_item.saturated)
  );

  // A held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_item.valid || out_item.ready))
    else $error("result register loaded while holding an untaken item");

  // No item is taken while the divider is running
  a_idle_divider: assert property (@(posedge clk) disable iff (!rst_n)
    in_item.ready |-> !stat.div_busy)
    else $error("input ready while divider busy");

  // After an item is taken, the next one waits
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_item.valid && in_item.ready) |=> !in_item.ready)
    else $error("second item accepted while one is in work");

  // Gain finishes only after the divider reports done
  a_div_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == ALU_DIV_FIN) |-> $past(stat.div_done))
    else $error("gain taken before divider finished");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for scalar_kalman_filter: measurement and restart items with random
// idling on both channels, each result predicted in Q16.16 and checked per field.
// Depends on skf_pkg, skf_if and the filter RTL.

module tb;
  import skf_pkg::*;

  typedef longint unsigned u64_t;

  // One filter output, as the result channel carries it
  typedef struct packed {
    fx_t  estimate;
    fx_t  gain;
    logic div_zero;
    logic saturated;
  } kf_out_t;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped index, write ignored
  localparam int     MAX_WAIT    = 12;
  localparam int     HOLD_CYCLES = 400;
  localparam int     STALL_LIMIT = 3000;
  localparam int     TAIL_CYCLES = 100;
  localparam longint SAT_HI      = 64'sd2147483647;
  localparam longint SAT_LO      = -64'sd2147483648;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  skf_in_if  in_ch ();
  skf_out_if out_ch ();

  scalar_kalman_filter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Filter state and register copies for prediction
  longint est_model = 0;
  longint cov_model = 0;
  longint q_model   = Q_NOISE_RST;
  longint r_model   = R_NOISE_RST;
  longint h_model   = H_GAIN_RST;
  bit     clamp_hit;

  kf_out_t filter_outputs_q[$];

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int hold_req   = 0;

  int err_count  = 0;
  int n_meas     = 0;
  int n_restart  = 0;
  int n_checked  = 0;
  int n_div_zero = 0;
  int n_sat      = 0;
  int quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- arithmetic

  function automatic longint sat32(input longint x);
    if (x > SAT_HI) begin
      clamp_hit = 1'b1;
      return SAT_HI;
    end
    if (x < SAT_LO) begin
      clamp_hit = 1'b1;
      return SAT_LO;
    end
    return x;
  endfunction

  function automatic u64_t mag_of(input longint x);
    return (x < 0) ? u64_t'(-x) : u64_t'(x);
  endfunction

  // Apply sign to a magnitude, clamping to the 32-bit range
  function automatic longint signed_of(input bit neg, input u64_t mag);
    if (neg) begin
      if (mag > u64_t'(SAT_HI) + 1) begin
        clamp_hit = 1'b1;
        return SAT_LO;
      end
      return -longint'(mag);
    end
    if (mag > u64_t'(SAT_HI)) begin
      clamp_hit = 1'b1;
      return SAT_HI;
    end
    return longint'(mag);
  endfunction

  // Q16.16 product, round half away from zero
  function automatic longint qmul(input longint a, input longint b);
    longint p;
    u64_t   m;
    p = a * b;
    m = mag_of(p);
    return signed_of(p < 0, (m + (u64_t'(1) << (FRAC_W - 1))) >> FRAC_W);
  endfunction

  // Q16.16 quotient, round half away from zero; divisor is never zero here
  function automatic longint qdiv(input longint n, input longint d);
    u64_t mn, md, q;
    mn = mag_of(n);
    md = mag_of(d);
    q  = ((mn << FRAC_W) + md / 2) / md;
    return signed_of((n < 0) != (d < 0), q);
  endfunction

  // One filter step: gain, estimate update, covariance update
  function automatic kf_out_t kf_update(input logic kind, input fx_t z_in);
    kf_out_t res;
    longint  z, hp, den, k, hx, innov, kh;
    res       = '0;
    clamp_hit = 1'b0;
    if (kind == KIND_RESTART) begin
      est_model = 0;
      cov_model = 0;
      return res;
    end
    z   = z_in;
    hp  = qmul(cov_model, h_model);
    den = sat32(qmul(hp, h_model) + sat32(r_model));
    if (den == 0) begin
      k            = 0;
      res.div_zero = 1'b1;
    end else begin
      k = qdiv(hp, den);
    end
    hx        = qmul(h_model, est_model);
    innov     = sat32(z - hx);
    est_model = sat32(est_model + qmul(k, innov));
    kh        = qmul(k, h_model);
    cov_model = sat32(qmul(sat32(longint'(FX_ONE) - kh), cov_model) + sat32(q_model));
    res.estimate  = fx_t'(est_model);
    res.gain      = fx_t'(k);
    res.saturated = clamp_hit;
    return res;
  endfunction

  // ---------------------------------------------------------------- monitors

  // Predict on every accepted input item
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (in_ch.kind == KIND_RESTART) n_restart++;
      else n_meas++;
      filter_outputs_q.push_back(kf_update(in_ch.kind, in_ch.measurement));
    end
  end

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_count++;
    end
  endtask

  // Compare every accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    kf_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (filter_outputs_q.size() == 0) begin
        $error("result item with no input item outstanding");
        err_count++;
      end else begin
        want = filter_outputs_q.pop_front();
        n_checked++;
        if (want.div_zero) n_div_zero++;
        if (want.saturated) n_sat++;
        check_field("estimate", want.estimate, out_ch.estimate);
        check_field("gain", want.gain, out_ch.gain);
        check_field("div_zero", want.div_zero, out_ch.div_zero);
        check_field("saturated", want.saturated, out_ch.saturated);
      end
    end
  end

  // Watchdog: too long without any handshake or register write
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", quiet_cycles);
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result receiver: random stall per item, or one long hold-off on request
  initial begin : receiver
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        stall    = hold_req;
        hold_req = 0;
      end else if (rx_idle_on) begin
        stall = $urandom_range(0, MAX_WAIT);
      end else begin
        stall = 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  // ---------------------------------------------------------------- drivers

  // Offer one item after a random gap; valid stays high on return
  task automatic send_item(input logic kind, input fx_t value);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= kind;
    in_ch.measurement <= value;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Stop offering and wait for every predicted result
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (filter_outputs_q.size() != 0) @(posedge clk);
  endtask

  // Write all three registers (plus the unmapped index if asked); block is idle
  task automatic write_config(input logic [CFG_DATA_W-1:0] q, r, h, input bit spare);
    logic [CFG_IDX_W-1:0]  idx  [4];
    logic [CFG_DATA_W-1:0] data [4];
    idx  = '{CFG_Q_NOISE, CFG_R_NOISE, CFG_H_GAIN, CFG_SPARE};
    data = '{q, r, h, $urandom};
    for (int i = 0; i < (spare ? 4 : 3); i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= data[i];
      @(posedge clk);
    end
    cfg_we  <= 1'b0;
    q_model = q[NOISE_W-1:0];
    r_model = r[NOISE_W-1:0];
    h_model = fx_t'(h);
  endtask

  function automatic fx_t rand_measurement();
    case ($urandom_range(0, 9))
      7:       return fx_t'($urandom);
      8: begin
        case ($urandom_range(0, 2))
          0:       return FX_MAX;
          1:       return FX_MIN;
          default: return '0;
        endcase
      end
      9:       return fx_t'(int'($urandom_range(0, 4 * 65536)) - 2 * 65536);
      default: return fx_t'(int'($urandom_range(0, 13107200)) - 6553600);  // +/-100.0
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_noise(input bit allow_zero);
    case ($urandom_range(0, 7))
      0:       return allow_zero ? '0 : 32'(FX_ONE);
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom;  // bit 31 is dropped by the register
      3:       return $urandom_range(0, 4096);
      default: return $urandom_range(1, 4 * 65536);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_h();
    case ($urandom_range(0, 7))
      0:       return FX_ONE;
      1:       return -FX_ONE;
      2:       return $urandom;
      3:       return FX_MIN;
      4:       return FX_MAX;
      default: return 32'(int'($urandom_range(0, 8 * 65536)) - 4 * 65536);
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  // Reset values, then a mild setting with nonzero gain
  task automatic test_defaults();
    send_item(KIND_RESTART, FX_MAX);
    send_item(KIND_MEASURE, '0);
    send_item(KIND_MEASURE, FX_MAX);
    send_item(KIND_MEASURE, FX_MIN);
    send_item(KIND_MEASURE, 3 * FX_ONE);
    drain_results();
    write_config(32'h0000_4000, FX_ONE, FX_ONE, 1'b1);
    send_item(KIND_MEASURE, 10 * FX_ONE);
    send_item(KIND_MEASURE, 12 * FX_ONE);
    send_item(KIND_MEASURE, -5 * FX_ONE);
    drain_results();
  endtask

  // Divisor H*H*P + R equal to zero: from P = 0 and from H = 0
  task automatic test_zero_divisor();
    write_config('0, '0, FX_ONE, 1'b0);
    send_item(KIND_RESTART, '0);
    send_item(KIND_MEASURE, 7 * FX_ONE);
    drain_results();
    write_config(FX_ONE, '0, FX_ONE, 1'b0);
    send_item(KIND_MEASURE, 7 * FX_ONE);
    send_item(KIND_MEASURE, 9 * FX_ONE);
    drain_results();
    write_config(FX_ONE, '0, '0, 1'b0);
    send_item(KIND_MEASURE, -FX_ONE);
    drain_results();
  endtask

  // Largest noise and gain magnitudes, clamping everywhere
  task automatic test_extremes();
    write_config(32'hFFFF_FFFF, 32'h7FFF_FFFF, FX_MIN, 1'b1);
    send_item(KIND_MEASURE, FX_MAX);
    send_item(KIND_MEASURE, FX_MIN);
    send_item(KIND_MEASURE, FX_MAX);
    send_item(KIND_RESTART, FX_MIN);
    drain_results();
    write_config(32'h7FFF_FFFF, '0, FX_MAX, 1'b0);
    send_item(KIND_MEASURE, FX_MIN);
    send_item(KIND_MEASURE, FX_MAX);
    send_item(KIND_MEASURE, -1);
    drain_results();
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    write_config(32'h0000_4000, FX_ONE, FX_ONE, 1'b0);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_req   = HOLD_CYCLES;
    repeat (8) send_item(KIND_MEASURE, rand_measurement());
    drain_results();
  endtask

  // Phases of random items, each with its own setting and idling mix
  task automatic test_random(input int n_items);
    int sent, phase_len;
    sent = 0;
    while (sent < n_items) begin
      drain_results();
      write_config(rand_noise(1'b0), rand_noise($urandom_range(0, 5) == 0), rand_h(),
                   $urandom_range(0, 3) == 0);
      tx_idle_on = $urandom_range(0, 3) != 0;
      rx_idle_on = $urandom_range(0, 3) != 0;
      phase_len  = $urandom_range(20, 120);
      if ($urandom_range(0, 1)) send_item(KIND_RESTART, fx_t'($urandom));
      repeat (phase_len) begin
        if ($urandom_range(0, 29) == 0) send_item(KIND_RESTART, fx_t'($urandom));
        else send_item(KIND_MEASURE, rand_measurement());
      end
      sent += phase_len;
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_Q_NOISE;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= KIND_MEASURE;
    in_ch.measurement <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_defaults();
    test_zero_divisor();
    test_extremes();
    test_backpressure();
    test_random(1500);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (filter_outputs_q.size() != 0) begin
      $error("%0d predicted results never arrived", filter_outputs_q.size());
      err_count++;
    end

    $display("summary: %0d measurements and %0d restarts sent, %0d results compared",
             n_meas, n_restart, n_checked);
    $display("summary: %0d zero-divisor steps, %0d clamped steps, %0d mismatches",
             n_div_zero, n_sat, err_count);
    if (err_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
